// File: hw/rtl/kth_smallest_selector_unit_assert.svh
`ifndef KTH_SMALLEST_SELECTOR_UNIT_ASSERT_SVH
`define KTH_SMALLEST_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define KSEL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kth smallest selector check failed");

// Next-cycle implication, checked while out of reset.
`define KSEL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kth smallest selector check failed");

`endif

// File: hw/rtl/ksel_pkg.sv
package ksel_pkg;

  localparam int VALUE_W      = 10;
  localparam int RANK_W       = 7;
  localparam int MAX_RANK_DEF = 64;
  localparam logic [VALUE_W-1:0] EMPTY_MARK = 10'h3FF;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_SHIFT,
    ST_DONE
  } ksel_state_t;

  typedef struct packed {
    logic insert;
    logic load;
    logic shift;
    logic finish;
  } ksel_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_busy;
  } ksel_sts_t;

endpackage

// File: hw/rtl/ksel_ifs.sv
interface ksel_in_if import ksel_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sample_value;
  logic               is_last;
  modport source(output valid, sample_value, is_last, input ready);
  modport sink(input valid, sample_value, is_last, output ready);
endinterface

interface ksel_out_if import ksel_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] kth_value;
  logic               too_few;
  modport source(output valid, kth_value, too_few, input ready);
  modport sink(input valid, kth_value, too_few, output ready);
endinterface

interface ksel_cfg_if import ksel_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] k_rank;
  modport source(output valid, k_rank, input ready);
  modport sink(input valid, k_rank, output ready);
endinterface

// File: hw/rtl/ksel_ctrl.sv
module ksel_ctrl import ksel_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_is_last,
  output logic      in_ready,
  input  ksel_sts_t sts,
  output ksel_cmd_t cmd
);

  ksel_state_t state_r;
  ksel_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_ACCEPT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.insert = 1'b1;
          if (in_is_last) begin
            cmd.load  = 1'b1;
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

endmodule

// File: hw/rtl/ksel_datapath.sv
module ksel_datapath import ksel_pkg::*; #(
  parameter int MAX_RANK = MAX_RANK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [VALUE_W-1:0] in_sample_value,
  input  logic               cfg_valid,
  input  logic [RANK_W-1:0]  cfg_k_rank,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_kth_value,
  output logic               out_too_few,
  input  ksel_cmd_t          cmd,
  output ksel_sts_t          sts
);

  localparam int FW = $clog2(MAX_RANK + 1);
  localparam int KW = (FW > RANK_W) ? FW : RANK_W;

  logic [VALUE_W-1:0] buf_r [MAX_RANK];
  logic [VALUE_W-1:0] ins_val [MAX_RANK];
  logic [MAX_RANK-1:0] keep;
  logic [FW-1:0]      filled_r;
  logic [FW-1:0]      filled_ins;
  logic [FW-1:0]      cnt_r;
  logic [FW-1:0]      k_eff;
  logic [KW-1:0]      k_ext;
  logic [RANK_W-1:0]  k_rank_r;
  logic               too_few_r;
  logic               full;
  logic               do_ins;
  logic               few;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [VALUE_W-1:0] out_kth_r;
  logic               out_too_few_r;

  assign full   = (filled_r == FW'(MAX_RANK));
  assign do_ins = cmd.insert && !(full && in_sample_value >= buf_r[MAX_RANK-1]);
  assign filled_ins = (cmd.insert && !full) ? filled_r + FW'(1) : filled_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_RANK; gi++) begin : g_cell
      assign keep[gi] = (FW'(gi) < filled_r) && (buf_r[gi] <= in_sample_value);
      if (gi == 0) begin : g_first
        assign ins_val[gi] = keep[gi] ? buf_r[gi] : in_sample_value;
      end else begin : g_rest
        assign ins_val[gi] = keep[gi]      ? buf_r[gi] :
                             keep[gi-1]    ? in_sample_value : buf_r[gi-1];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        buf_r[i] <= ins_val[i];
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < MAX_RANK - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  always_comb begin
    k_ext = KW'(k_rank_r);
    if (k_ext == '0) begin
      k_eff = FW'(1);
    end else if (k_ext > KW'(MAX_RANK)) begin
      k_eff = FW'(MAX_RANK);
    end else begin
      k_eff = k_ext[FW-1:0];
    end
  end

  assign few = filled_ins < k_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      k_rank_r <= RANK_W'(1);
      cnt_r    <= '0;
    end else begin
      if (cfg_valid) begin
        k_rank_r <= cfg_k_rank;
      end
      if (cmd.finish) begin
        filled_r <= '0;
      end else begin
        filled_r <= filled_ins;
      end
      if (cmd.load) begin
        cnt_r <= few ? '0 : k_eff - FW'(1);
      end else if (cmd.shift) begin
        cnt_r <= cnt_r - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      too_few_r <= few;
    end
    if (cmd.finish) begin
      out_kth_r     <= too_few_r ? EMPTY_MARK : buf_r[0];
      out_too_few_r <= too_few_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_kth_value = out_kth_r;
  assign out_too_few   = out_too_few_r;

endmodule

// File: hw/rtl/kth_smallest_selector_unit.sv
// Channel   Direction  Payload
// in_ch     sink       sample_value[9:0], is_last
// out_ch    source     kth_value[9:0], too_few
// cfg_ch    sink       k_rank[6:0]
//
// Items without the last mark stream back to back.
// After an item with the last mark, the kept buffer shifts down one entry per cycle
// until the clamped rank k is reached; a set with too few values skips the shifting.
// The result sits in an output register, so input resumes while it waits to be taken.
// A stalled output holds the block only when a new result is ready to be loaded.
// Reset is synchronous and active low; it empties the buffer and sets the rank to 1.
module kth_smallest_selector_unit import ksel_pkg::*; #(
  parameter int MAX_RANK = MAX_RANK_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ksel_in_if.sink    in_ch,
  ksel_out_if.source out_ch,
  ksel_cfg_if.sink   cfg_ch
);

  ksel_cmd_t cmd;
  ksel_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  ksel_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_is_last (in_ch.is_last),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ksel_datapath #(
    .MAX_RANK (MAX_RANK)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample_value (in_ch.sample_value),
    .cfg_valid       (cfg_ch.valid),
    .cfg_k_rank      (cfg_ch.k_rank),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kth_value   (out_ch.kth_value),
    .out_too_few     (out_ch.too_few),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// File: hw/rtl/ksel_checker.sv
`include "kth_smallest_selector_unit_assert.svh"

module ksel_checker import ksel_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_is_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] kth_value,
  input logic               too_few
);

  `KSEL_ASSERT_IMP(a_few_marker, out_valid && too_few, kth_value == EMPTY_MARK)
  `KSEL_ASSERT_NXT(a_last_blocks, in_valid && in_ready && in_is_last, !in_ready)
  `KSEL_ASSERT_NXT(a_plain_streams, in_valid && in_ready && !in_is_last, in_ready)
  `KSEL_ASSERT_NXT(a_out_holds, out_valid && !out_ready,
                   out_valid && $stable(kth_value) && $stable(too_few))

endmodule

bind kth_smallest_selector_unit ksel_checker u_ksel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_is_last (in_ch.is_last),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kth_value  (out_ch.kth_value),
  .too_few    (out_ch.too_few)
);

// File: bench/kth_rank_checker.sv
`timescale 1ns / 1ps

module kth_rank_checker import ksel_pkg::*; #(
  parameter int MAX_RANK = MAX_RANK_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ksel_in_if   in_mon,
  ksel_out_if  out_mon,
  ksel_cfg_if  cfg_mon,
  output int   mismatches,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    logic [VALUE_W-1:0] kth_value;
    logic               too_few;
  } kth_result_t;

  logic [VALUE_W-1:0] kept [MAX_RANK];
  int                 kept_count;
  logic [RANK_W-1:0]  rank_setting;
  kth_result_t        expected_kth [$];

  function automatic void clear_kept();
    int i;
    for (i = 0; i < MAX_RANK; i++) kept[i] = EMPTY_MARK;
    kept_count = 0;
  endfunction

  // The kept list holds the smallest values of the set in ascending order.
  function automatic void keep_if_smaller(logic [VALUE_W-1:0] v);
    int top;
    int pos;
    int i;
    if (kept_count >= MAX_RANK) begin
      if (v >= kept[MAX_RANK-1]) return;
      top = MAX_RANK - 1;
    end else begin
      top = kept_count;
      kept_count++;
    end
    pos = 0;
    while (pos < top && kept[pos] <= v) pos++;
    for (i = top; i > pos; i--) kept[i] = kept[i-1];
    kept[pos] = v;
  endfunction

  function automatic kth_result_t rank_result();
    int          k;
    kth_result_t r;
    k = rank_setting;
    if (k == 0) k = 1;
    if (k > MAX_RANK) k = MAX_RANK;
    if (kept_count < k) begin
      r.kth_value = EMPTY_MARK;
      r.too_few   = 1'b1;
    end else begin
      r.kth_value = kept[k-1];
      r.too_few   = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("[%0t] kth check failed: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    kth_result_t got;
    kth_result_t want;
    if (!rst_n) begin
      clear_kept();
      rank_setting = 1;
      expected_kth.delete();
      mismatches   = 0;
      checked      = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) rank_setting = cfg_mon.k_rank;
      if (in_mon.valid && in_mon.ready) begin
        keep_if_smaller(in_mon.sample_value);
        if (in_mon.is_last) begin
          expected_kth.push_back(rank_result());
          clear_kept();
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.kth_value = out_mon.kth_value;
        got.too_few   = out_mon.too_few;
        if (expected_kth.size() == 0) begin
          report_mismatch($sformatf("unexpected item, kth_value %0d too_few %0b",
                                    got.kth_value, got.too_few));
        end else begin
          want = expected_kth.pop_front();
          checked++;
          if (got.kth_value !== want.kth_value)
            report_mismatch($sformatf("kth_value %0d, expected %0d",
                                      got.kth_value, want.kth_value));
          if (got.too_few !== want.too_few)
            report_mismatch($sformatf("too_few %0b, expected %0b",
                                      got.too_few, want.too_few));
        end
      end
    end
    pending = expected_kth.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import ksel_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = MAX_RANK_DEF + 16;
  localparam int SAMPLE_TARGET = 1800;

  typedef enum {
    MIX_WIDE,
    MIX_DUPS,
    MIX_EDGE
  } value_mix_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet;
  int   cycle_count;
  int   samples_sent;
  int   sets_sent;
  int   rank_writes;
  int   mismatches;
  int   pending;
  int   checked;

  ksel_in_if  in_ch ();
  ksel_out_if out_ch ();
  ksel_cfg_if cfg_ch ();

  kth_smallest_selector_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  kth_rank_checker rank_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("kth_smallest_selector_unit: mismatch");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int clamp_rank(int k);
    if (k == 0) return 1;
    if (k > MAX_RANK_DEF) return MAX_RANK_DEF;
    return k;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(value_mix_t mix);
    case (mix)
      MIX_DUPS: begin
        return VALUE_W'($urandom_range(1, 6));
      end
      MIX_EDGE: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return VALUE_W'(1);
          2: return VALUE_W'(1000);
          3: return VALUE_W'($urandom_range(1001, 1022));
          default: return EMPTY_MARK;
        endcase
      end
      default: begin
        return VALUE_W'($urandom_range(1, 1000));
      end
    endcase
  endfunction

  always begin
    int gap;
    @(posedge clk);
    gap = gap_len();
    if (gap > 0) begin
      out_ch.ready <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    out_ch.ready <= 1'b1;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  end

  task automatic send_sample(input logic [VALUE_W-1:0] v, input logic last);
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= v;
    in_ch.is_last      <= last;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    samples_sent++;
    if (last) sets_sent++;
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rank(input logic [RANK_W-1:0] k);
    wait_drained();
    cfg_ch.valid  <= 1'b1;
    cfg_ch.k_rank <= k;
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    rank_writes++;
  endtask

  task automatic send_set(input int len, input value_mix_t mix);
    int i;
    for (i = 0; i < len; i++) begin
      send_sample(pick_value(mix), i == len - 1);
      pause_input(gap_len());
    end
  endtask

  initial begin
    int               phase;
    int               n_sets;
    int               keff;
    int               len;
    int               r;
    logic [RANK_W-1:0] k;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sample_value = '0;
    in_ch.is_last     = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.k_rank     = '0;
    cycle_count       = 0;
    quiet             = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(10'd5, 1'b0);
    send_sample(EMPTY_MARK, 1'b0);
    send_sample(10'd0, 1'b1);
    send_sample(10'd1000, 1'b1);
    write_rank(7'd3);
    send_sample(10'd7, 1'b0);
    send_sample(10'd7, 1'b0);
    send_sample(10'd7, 1'b1);
    send_sample(10'd2, 1'b0);
    send_sample(10'd9, 1'b1);
    write_rank(7'd0);
    send_sample(10'd4, 1'b0);
    send_sample(10'd3, 1'b1);
    write_rank(7'd127);
    send_sample(10'd1, 1'b1);

    phase = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      case (phase % 7)
        0: k = 7'd64;
        1: k = 7'd1;
        2: k = 7'd0;
        3: k = 7'd127;
        4: k = 7'd65;
        5: k = 7'd2;
        default: k = RANK_W'($urandom_range(0, 127));
      endcase
      write_rank(k);
      quiet = ($urandom_range(0, 3) == 0);
      keff = clamp_rank(k);
      n_sets = $urandom_range(6, 16);
      repeat (n_sets) begin
        if (samples_sent < SAMPLE_TARGET) begin
          r = $urandom_range(0, 99);
          if (r < 10) len = 1;
          else if (r < 35) len = $urandom_range(1, keff);
          else if (r < 75) len = $urandom_range(keff, keff + 8);
          else if (r < 92) len = $urandom_range(1, 12);
          else len = $urandom_range(65, 130);
          r = $urandom_range(0, 99);
          if (r < 70) send_set(len, MIX_WIDE);
          else if (r < 85) send_set(len, MIX_DUPS);
          else send_set(len, MIX_EDGE);
        end
      end
      phase++;
    end

    quiet = 1'b0;
    wait_drained();
    $display("Streamed %0d samples in %0d sets across %0d rank settings.",
             samples_sent, sets_sent, rank_writes + 1);
    $display("Checked %0d rank results, including full, short and duplicate sets.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("kth_smallest_selector_unit: match");
    end else begin
      $display("kth_smallest_selector_unit: mismatch");
    end
    $finish;
  end

endmodule
